>>> hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Entry, channel payload and cell control types, command and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_W   = 7;
    localparam int OCC_W   = 7;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int DATA_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] prio_value;
    } spq_in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] out_item;
        logic signed [DATA_W-1:0] out_prio;
        logic [OCC_W-1:0]         occupancy;
    } spq_out_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] item;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    // Broadcast to every cell: the operation that commits this cycle.
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctl_t;

endpackage

>>> hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: shift-register priority queue
// Results are registered at input transfer; one operation per cycle unless
// m_ready stalls the output. All cells compare and shift in parallel.
// Reset: occupancy clears to zero and capacity returns to 64; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  spq_pkg::spq_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output spq_pkg::spq_out_t             m_data,
    input  logic                          cfg_we,
    input  logic [spq_pkg::CAP_W-1:0]     cfg_wdata
);
    import spq_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    spq_out_t         m_data_reg;
    spq_out_t         result;

    logic      accept;
    logic      full;
    logic      empty;
    cell_ctl_t ctl;

    logic   [DEPTH-1:0] take;
    logic   [DEPTH-1:0] occupied;
    entry_t             entries [DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Effective capacity saturates at DEPTH; count never exceeds DEPTH.
    assign full  = (CMP_W'(count_reg) >= CMP_W'(cap_reg)) || (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb begin
        ctl.enq            = accept && (s_data.cmd == CMD_ENQ) && !full;
        ctl.deq            = accept && (s_data.cmd == CMD_DEQ) && !empty;
        ctl.new_entry.item = s_data.item_value;
        ctl.new_entry.prio = s_data.prio_value;
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.enq) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctl.deq) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        result.status    = STATUS_DONE;
        result.out_item  = '0;
        result.out_prio  = '0;
        result.occupancy = OCC_W'(count_next);
        unique case (s_data.cmd)
            CMD_ENQ: begin
                if (full) begin
                    result.status = STATUS_FULL;
                end
            end
            CMD_DEQ: begin
                if (empty) begin
                    result.status = STATUS_EMPTY;
                end else begin
                    result.out_item = entries[0].item;
                    result.out_prio = entries[0].prio;
                end
            end
            default: begin
                result.status = STATUS_DONE;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            assign occupied[i] = (CNT_W'(i) < count_reg);

            if (i == 0) begin : g_head
                spq_cell u_cell (
                    .aclk        (aclk),
                    .ctl         (ctl),
                    .occupied    (occupied[i]),
                    .left_take   (1'b0),
                    .left_entry  ('0),
                    .right_entry (entries[i+1]),
                    .take        (take[i]),
                    .entry       (entries[i])
                );
            end else if (i == DEPTH - 1) begin : g_tail
                spq_cell u_cell (
                    .aclk        (aclk),
                    .ctl         (ctl),
                    .occupied    (occupied[i]),
                    .left_take   (take[i-1]),
                    .left_entry  (entries[i-1]),
                    .right_entry ('0),
                    .take        (take[i]),
                    .entry       (entries[i])
                );
            end else begin : g_mid
                spq_cell u_cell (
                    .aclk        (aclk),
                    .ctl         (ctl),
                    .occupied    (occupied[i]),
                    .left_take   (take[i-1]),
                    .left_entry  (entries[i-1]),
                    .right_entry (entries[i+1]),
                    .take        (take[i]),
                    .entry       (entries[i])
                );
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            // Hold the result until the downstream transfer completes.
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.enq && ctl.deq))
        else $error("enqueue and dequeue commit together");

    a_enq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.enq |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("enqueue did not advance count");

    a_result_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_data_reg.occupancy == OCC_W'(count_reg)))
        else $error("result occupancy differs from count");
`endif

endmodule

>>> hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift-register queue
// Holds one entry; on enqueue it keeps, takes the new entry or takes its left
// neighbor's entry; on dequeue it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               aclk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  logic               left_take,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               take,
    output spq_pkg::entry_t    entry
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // New entry goes at or before this slot when the slot is free or holds
    // a strictly greater priority; equal priorities stay ahead.
    assign take  = !occupied || (entry_reg.prio > ctl.new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.enq) begin
            if (left_take) begin
                entry_next = left_entry;
            end else if (take) begin
                entry_next = ctl.new_entry;
            end
        end else if (ctl.deq) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule
